### hw/rtl/tas_pkg.sv
// Shared types and constants of the triangle area sorter.
`timescale 1ns / 1ps
`default_nettype none

package tas_pkg;

   localparam int SIDE_BITS = 12;

   typedef struct packed {
      logic [SIDE_BITS-1:0] side_a;
      logic [SIDE_BITS-1:0] side_b;
      logic [SIDE_BITS-1:0] side_c;
      logic                 batch_end;
   } req_type;

   typedef struct packed {
      logic [SIDE_BITS-1:0] out_a;
      logic [SIDE_BITS-1:0] out_b;
      logic [SIDE_BITS-1:0] out_c;
      logic                 out_last;
   } rsp_type;

   typedef struct packed {
      logic [SIDE_BITS-1:0] a;
      logic [SIDE_BITS-1:0] b;
      logic [SIDE_BITS-1:0] c;
   } tri_type;

   typedef struct packed {
      logic insert;
      logic shift;
   } cell_ctl_type;

endpackage

`default_nettype wire

### hw/rtl/tas_key_unit.sv
// Three-stage pipeline that computes the squared-area sort key of a triangle.
`timescale 1ns / 1ps
`default_nettype none

module tas_key_unit #(
   parameter int SIDE_WIDTH = 12,
   parameter int KEY_WIDTH  = 4 * SIDE_WIDTH + 5
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   input  wire tas_pkg::req_type       in_data,
   output logic                        out_valid,
   output logic                        out_last,
   output tas_pkg::tri_type            out_tri,
   output logic [KEY_WIDTH-1:0]        out_key,
   output logic                        last_pending
);

   localparam int SumWidth = SIDE_WIDTH + 2;
   localparam int FacWidth = SIDE_WIDTH + 1;
   localparam int P1Width  = SumWidth + FacWidth;
   localparam int P2Width  = 2 * FacWidth;

   logic [SumWidth-1:0] a_w, b_w, c_w, ab_w, ac_w, bc_w;

   logic                st1_valid_ff, st1_valid_in;
   logic                st1_last_ff;
   tas_pkg::tri_type    st1_tri_ff, st1_tri_in;
   logic [SumWidth-1:0] st1_sum_ff, st1_sum_in;
   logic [FacWidth-1:0] st1_f1_ff, st1_f1_in;
   logic [FacWidth-1:0] st1_f2_ff, st1_f2_in;
   logic [FacWidth-1:0] st1_f3_ff, st1_f3_in;

   logic                st2_valid_ff;
   logic                st2_last_ff;
   tas_pkg::tri_type    st2_tri_ff;
   logic [P1Width-1:0]  st2_p1_ff, st2_p1_in;
   logic [P2Width-1:0]  st2_p2_ff, st2_p2_in;

   logic                st3_valid_ff;
   logic                st3_last_ff;
   tas_pkg::tri_type    st3_tri_ff;
   logic [KEY_WIDTH-1:0] st3_key_ff, st3_key_in;

   always_comb begin
      a_w  = SumWidth'(in_data.side_a[SIDE_WIDTH-1:0]);
      b_w  = SumWidth'(in_data.side_b[SIDE_WIDTH-1:0]);
      c_w  = SumWidth'(in_data.side_c[SIDE_WIDTH-1:0]);
      ab_w = a_w + b_w;
      ac_w = a_w + c_w;
      bc_w = b_w + c_w;
      st1_valid_in = in_valid;
      st1_tri_in.a = tas_pkg::SIDE_BITS'(in_data.side_a[SIDE_WIDTH-1:0]);
      st1_tri_in.b = tas_pkg::SIDE_BITS'(in_data.side_b[SIDE_WIDTH-1:0]);
      st1_tri_in.c = tas_pkg::SIDE_BITS'(in_data.side_c[SIDE_WIDTH-1:0]);
      st1_sum_in = ab_w + c_w;
      if ((bc_w > a_w) && (ac_w > b_w) && (ab_w > c_w)) begin
         st1_f1_in = FacWidth'(bc_w - a_w);
         st1_f2_in = FacWidth'(ac_w - b_w);
         st1_f3_in = FacWidth'(ab_w - c_w);
      end else begin
         st1_f1_in = '0;
         st1_f2_in = '0;
         st1_f3_in = '0;
      end
      st2_p1_in  = P1Width'(st1_sum_ff) * P1Width'(st1_f1_ff);
      st2_p2_in  = P2Width'(st1_f2_ff) * P2Width'(st1_f3_ff);
      st3_key_in = KEY_WIDTH'(st2_p1_ff) * KEY_WIDTH'(st2_p2_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st1_valid_ff <= 1'b0;
         st2_valid_ff <= 1'b0;
         st3_valid_ff <= 1'b0;
      end else begin
         st1_valid_ff <= st1_valid_in;
         st2_valid_ff <= st1_valid_ff;
         st3_valid_ff <= st2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      st1_last_ff <= in_data.batch_end;
      st1_tri_ff  <= st1_tri_in;
      st1_sum_ff  <= st1_sum_in;
      st1_f1_ff   <= st1_f1_in;
      st1_f2_ff   <= st1_f2_in;
      st1_f3_ff   <= st1_f3_in;
      st2_last_ff <= st1_last_ff;
      st2_tri_ff  <= st1_tri_ff;
      st2_p1_ff   <= st2_p1_in;
      st2_p2_ff   <= st2_p2_in;
      st3_last_ff <= st2_last_ff;
      st3_tri_ff  <= st2_tri_ff;
      st3_key_ff  <= st3_key_in;
   end

   assign out_valid    = st3_valid_ff;
   assign out_last     = st3_last_ff;
   assign out_tri      = st3_tri_ff;
   assign out_key      = st3_key_ff;
   assign last_pending = (st1_valid_ff && st1_last_ff) || (st2_valid_ff && st2_last_ff)
                         || (st3_valid_ff && st3_last_ff);

endmodule

`default_nettype wire

### hw/rtl/tas_cell.sv
// One slot of the insertion chain: holds a triangle and its key.
`timescale 1ns / 1ps
`default_nettype none

module tas_cell #(
   parameter int KEY_WIDTH = 53,
   parameter bit IS_FIRST  = 1'b0
) (
   input  wire logic                   clock,
   input  wire tas_pkg::cell_ctl_type  ctl,
   input  wire logic                   occupied,
   input  wire logic [KEY_WIDTH-1:0]   new_key,
   input  wire tas_pkg::tri_type       new_tri,
   input  wire logic                   prev_cond,
   input  wire logic [KEY_WIDTH-1:0]   prev_key,
   input  wire tas_pkg::tri_type       prev_tri,
   input  wire logic [KEY_WIDTH-1:0]   next_key,
   input  wire tas_pkg::tri_type       next_tri,
   output logic                        cond,
   output logic [KEY_WIDTH-1:0]        key,
   output tas_pkg::tri_type            tri_out
);

   logic [KEY_WIDTH-1:0] key_ff, key_in;
   tas_pkg::tri_type     tri_ff, tri_in;

   // The slot yields when it is empty or holds a strictly larger key.
   assign cond = !occupied || (key_ff > new_key);

   always_comb begin
      key_in = key_ff;
      tri_in = tri_ff;
      if (ctl.shift) begin
         key_in = next_key;
         tri_in = next_tri;
      end else if (ctl.insert && cond) begin
         if (!IS_FIRST && prev_cond) begin
            key_in = prev_key;
            tri_in = prev_tri;
         end else begin
            key_in = new_key;
            tri_in = new_tri;
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      tri_ff <= tri_in;
   end

   assign key     = key_ff;
   assign tri_out = tri_ff;

endmodule

`default_nettype wire

### hw/rtl/triangle_area_sorter.sv
// Top level of the triangle area sorter: key pipeline, insertion chain and output stage.
//
// Triangles arrive on the req_ channel, one beat per triangle, and may come in every
// cycle while req_stall is low. Each beat's key passes a three-stage multiply
// pipeline and is then placed in a chain of MAX_ITEMS cells, which keeps the batch
// sorted by area at all times. The beat with batch_end set closes the batch;
// req_stall stays high from the cycle after that beat until the whole batch has been
// handed to the output register. The first result of a batch becomes valid once the
// closing beat has passed the three key stages, the drain flag and the output
// register, and then one result follows per cycle while rsp_stall is low; the chain
// shifts one cell toward the output for each result taken. Triangles beyond MAX_ITEMS
// are dropped, but their batch_end still closes the batch. While rsp_stall is high the
// output register holds its beat and the chain waits behind it. Reset empties the chain
// and the pipeline and clears both valid signals; stored triangles need no clearing.
`timescale 1ns / 1ps
`default_nettype none

module triangle_area_sorter #(
   parameter int MAX_ITEMS  = 64,
   parameter int SIDE_WIDTH = 12
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire tas_pkg::req_type  req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output tas_pkg::rsp_type       rsp_data
);

   localparam int KeyWidth = 4 * SIDE_WIDTH + 5;
   localparam int CntWidth = $clog2(MAX_ITEMS + 1);

   logic                  kv_valid, kv_last, last_pending;
   tas_pkg::tri_type      kv_tri;
   logic [KeyWidth-1:0]   kv_key;

   logic [CntWidth-1:0]   fill_count_ff, fill_count_in;
   logic                  drain_ff, drain_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   tas_pkg::rsp_type      rsp_data_ff, rsp_data_in;

   logic                  insert_w, emit_w;
   tas_pkg::cell_ctl_type ctl;
   logic [MAX_ITEMS-1:0]  occ;
   logic [MAX_ITEMS-1:0]  cell_cond;
   logic [KeyWidth-1:0]   cell_key [MAX_ITEMS];
   tas_pkg::tri_type      cell_tri [MAX_ITEMS];

   tas_key_unit #(
      .SIDE_WIDTH (SIDE_WIDTH),
      .KEY_WIDTH  (KeyWidth)
   ) u_key (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_valid && !req_stall),
      .in_data      (req_data),
      .out_valid    (kv_valid),
      .out_last     (kv_last),
      .out_tri      (kv_tri),
      .out_key      (kv_key),
      .last_pending (last_pending)
   );

   assign insert_w   = kv_valid && (fill_count_ff < CntWidth'(MAX_ITEMS));
   assign emit_w     = drain_ff && (!rsp_valid_ff || !rsp_stall);
   assign ctl.insert = insert_w;
   assign ctl.shift  = emit_w;

   genvar i;
   generate
      for (i = 0; i < MAX_ITEMS; i++) begin : g_cell
         logic                prev_cond_w;
         logic [KeyWidth-1:0] prev_key_w, next_key_w;
         tas_pkg::tri_type    prev_tri_w, next_tri_w;

         assign occ[i] = fill_count_ff > CntWidth'(i);

         if (i == 0) begin : g_head
            assign prev_cond_w = 1'b0;
            assign prev_key_w  = '0;
            assign prev_tri_w  = '0;
         end else begin : g_body
            assign prev_cond_w = cell_cond[i-1];
            assign prev_key_w  = cell_key[i-1];
            assign prev_tri_w  = cell_tri[i-1];
         end

         if (i == MAX_ITEMS - 1) begin : g_tail
            assign next_key_w = cell_key[i];
            assign next_tri_w = cell_tri[i];
         end else begin : g_link
            assign next_key_w = cell_key[i+1];
            assign next_tri_w = cell_tri[i+1];
         end

         tas_cell #(
            .KEY_WIDTH (KeyWidth),
            .IS_FIRST  (i == 0)
         ) u_cell (
            .clock     (clock),
            .ctl       (ctl),
            .occupied  (occ[i]),
            .new_key   (kv_key),
            .new_tri   (kv_tri),
            .prev_cond (prev_cond_w),
            .prev_key  (prev_key_w),
            .prev_tri  (prev_tri_w),
            .next_key  (next_key_w),
            .next_tri  (next_tri_w),
            .cond      (cell_cond[i]),
            .key       (cell_key[i]),
            .tri_out   (cell_tri[i])
         );
      end
   endgenerate

   always_comb begin
      fill_count_in = fill_count_ff;
      drain_in      = drain_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      if (insert_w) begin
         fill_count_in = fill_count_ff + CntWidth'(1);
      end
      if (kv_valid && kv_last) begin
         drain_in = 1'b1;
      end
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (emit_w) begin
         rsp_valid_in         = 1'b1;
         rsp_data_in.out_a    = cell_tri[0].a;
         rsp_data_in.out_b    = cell_tri[0].b;
         rsp_data_in.out_c    = cell_tri[0].c;
         rsp_data_in.out_last = (fill_count_ff == CntWidth'(1));
         fill_count_in        = fill_count_ff - CntWidth'(1);
         if (fill_count_ff == CntWidth'(1)) begin
            drain_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_count_ff <= '0;
         drain_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         fill_count_ff <= fill_count_in;
         drain_ff      <= drain_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = drain_ff || last_pending;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

### hw/rtl/tas_checker.sv
// Port-level assertions for the triangle area sorter and the bind that attaches them.
`timescale 1ns / 1ps
`default_nettype none

module tas_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_stall,
   input wire tas_pkg::req_type  req_data,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire tas_pkg::rsp_type  rsp_data
);

   // A held result beat keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");

   // The closing beat of a batch blocks further input.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.batch_end |=> req_stall)
      else $error("input not stalled after batch close");

   // A closed batch yields a result via key stages, drain flag, output register.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.batch_end |-> ##5 rsp_valid)
      else $error("no result after batch close");

   // Reset leaves no result pending.
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind triangle_area_sorter tas_checker u_tas_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire

### tb/sv/triangle_area_sorter_checker.sv
// Scoreboard that predicts each sorted batch of the triangle area sorter and checks its beats.
`timescale 1ns / 1ps
`default_nettype none

module triangle_area_sorter_checker #(
   parameter int MAX_ITEMS = 64
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic             req_stall,
   input  wire tas_pkg::req_type req_data,
   input  wire logic             rsp_valid,
   input  wire logic             rsp_stall,
   input  wire tas_pkg::rsp_type rsp_data,
   output int                    error_count,
   output int                    pending_count,
   output int                    checked_count
);

   typedef logic [63:0] area_key_type;

   tas_pkg::tri_type sorted_tris [MAX_ITEMS];
   area_key_type     sorted_keys [MAX_ITEMS];
   int               stored_count = 0;
   int               errors = 0;
   int               checked = 0;
   tas_pkg::rsp_type sorted_out_q [$];

   function automatic area_key_type heron_key16(tas_pkg::tri_type t);
      area_key_type a;
      area_key_type b;
      area_key_type c;
      a = t.a;
      b = t.b;
      c = t.c;
      if (b + c <= a || a + c <= b || a + b <= c) return '0;
      return (a + b + c) * (b + c - a) * (a + c - b) * (a + b - c);
   endfunction

   task automatic insert_triangle(tas_pkg::tri_type t);
      area_key_type k;
      int pos;
      k = heron_key16(t);
      pos = stored_count;
      while (pos > 0 && sorted_keys[pos-1] > k) begin
         sorted_tris[pos] = sorted_tris[pos-1];
         sorted_keys[pos] = sorted_keys[pos-1];
         pos--;
      end
      sorted_tris[pos] = t;
      sorted_keys[pos] = k;
      stored_count++;
   endtask

   task automatic close_batch();
      tas_pkg::rsp_type beat;
      for (int i = 0; i < stored_count; i++) begin
         beat.out_a = sorted_tris[i].a;
         beat.out_b = sorted_tris[i].b;
         beat.out_c = sorted_tris[i].c;
         beat.out_last = (i == stored_count - 1);
         sorted_out_q.push_back(beat);
      end
      stored_count = 0;
   endtask

   task automatic check_beat(tas_pkg::rsp_type got);
      tas_pkg::rsp_type want;
      if (sorted_out_q.size() == 0) begin
         errors++;
         if (errors <= 10) begin
            $display("unexpected result beat: a=%0d b=%0d c=%0d last=%b",
                     got.out_a, got.out_b, got.out_c, got.out_last);
         end
         return;
      end
      want = sorted_out_q.pop_front();
      checked++;
      if (got.out_a !== want.out_a || got.out_b !== want.out_b ||
          got.out_c !== want.out_c || got.out_last !== want.out_last) begin
         errors++;
         if (errors <= 10) begin
            $display("mismatch on result %0d: expected a=%0d b=%0d c=%0d last=%b,",
                     checked, want.out_a, want.out_b, want.out_c, want.out_last);
            $display("   got a=%0d b=%0d c=%0d last=%b",
                     got.out_a, got.out_b, got.out_c, got.out_last);
         end
      end
   endtask

   always @(posedge clock) begin
      tas_pkg::tri_type t;
      if (reset) begin
         stored_count = 0;
         sorted_out_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) check_beat(rsp_data);
         if (req_valid && !req_stall) begin
            t.a = req_data.side_a;
            t.b = req_data.side_b;
            t.c = req_data.side_c;
            if (stored_count < MAX_ITEMS) insert_triangle(t);
            if (req_data.batch_end) close_batch();
         end
      end
      error_count <= errors;
      checked_count <= checked;
      pending_count <= sorted_out_q.size();
   end

endmodule

`default_nettype wire

### tb/sv/triangle_area_sorter_test.sv
// Top of the triangle area sorter testbench: clock, reset, beat stimulus, result stalls and verdict.
`timescale 1ns / 1ps
`default_nettype none

module triangle_area_sorter_test;

   localparam int MAX_ITEMS    = 64;
   localparam int SIDE_MAX     = (1 << tas_pkg::SIDE_BITS) - 1;
   localparam int RANDOM_ITEMS = 110;

   logic             clock;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   tas_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   tas_pkg::rsp_type rsp_data;

   int      error_count;
   int      pending_count;
   int      checked_count;

   int      items_sent = 0;
   int      batches_sent = 0;
   int      items_dropped = 0;
   logic    rsp_calm = 1'b0;
   int      stall_left = 0;

   triangle_area_sorter #(
      .MAX_ITEMS  (MAX_ITEMS),
      .SIDE_WIDTH (tas_pkg::SIDE_BITS)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   triangle_area_sorter_checker #(
      .MAX_ITEMS (MAX_ITEMS)
   ) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .error_count   (error_count),
      .pending_count (pending_count),
      .checked_count (checked_count)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   always @(posedge clock) begin
      if (rsp_calm) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end else begin
         rsp_stall <= !rsp_stall;
         stall_left <= rsp_stall ? $urandom_range(0, 6) : pick_gap();
      end
   end

   task automatic send_triangle(input int a, input int b, input int c, input logic last,
                                input bit idle);
      tas_pkg::req_type beat;
      int gap;
      beat.side_a = a[tas_pkg::SIDE_BITS-1:0];
      beat.side_b = b[tas_pkg::SIDE_BITS-1:0];
      beat.side_c = c[tas_pkg::SIDE_BITS-1:0];
      beat.batch_end = last;
      req_valid <= 1'b1;
      req_data <= beat;
      do @(posedge clock); while (req_stall);
      items_sent++;
      gap = idle ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   function automatic tas_pkg::tri_type random_triangle(int top_side, bit have_prev,
                                                        tas_pkg::tri_type prev);
      tas_pkg::tri_type t;
      int kind;
      int a;
      int b;
      int c;
      int lo;
      int hi;
      int half;
      kind = $urandom_range(0, 99);
      if (!have_prev && kind >= 60 && kind < 85) kind = 0;
      half = (top_side / 2 > 0) ? top_side / 2 : 1;
      if (kind < 45) begin
         a = $urandom_range(1, top_side);
         b = $urandom_range(1, top_side);
         lo = (a > b ? a - b : b - a) + 1;
         hi = (a + b - 1 < top_side) ? a + b - 1 : top_side;
         c = $urandom_range(lo, hi);
      end else if (kind < 60) begin
         a = $urandom_range(1, top_side);
         b = $urandom_range(1, top_side);
         c = $urandom_range(1, top_side);
      end else if (kind < 75) begin
         a = prev.a;
         b = prev.b;
         c = prev.c;
      end else if (kind < 85) begin
         a = prev.b;
         b = prev.c;
         c = prev.a;
      end else if (kind < 93) begin
         a = $urandom_range(1, half);
         b = $urandom_range(1, half);
         c = a + b;
      end else begin
         a = ($urandom_range(0, 1) != 0) ? SIDE_MAX : $urandom_range(2047, 2048);
         b = ($urandom_range(0, 1) != 0) ? SIDE_MAX : 1;
         c = ($urandom_range(0, 1) != 0) ? SIDE_MAX : $urandom_range(1, 2);
      end
      t.a = a[tas_pkg::SIDE_BITS-1:0];
      t.b = b[tas_pkg::SIDE_BITS-1:0];
      t.c = c[tas_pkg::SIDE_BITS-1:0];
      return t;
   endfunction

   initial begin
      int random_sent;
      int batch_size;
      int top_side;
      int r;
      bit idle;
      tas_pkg::tri_type t;
      tas_pkg::tri_type prev;

      random_sent = 0;
      prev = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      idle = 1'b1;
      send_triangle(4095, 4095, 4095, 1'b1, idle);
      batches_sent++;
      wait_drained();

      send_triangle(4095, 4095, 4095, 1'b0, idle);
      send_triangle(1, 1, 1, 1'b0, idle);
      send_triangle(3, 4, 5, 1'b0, idle);
      send_triangle(5, 3, 4, 1'b0, idle);
      send_triangle(1, 2, 3, 1'b0, idle);
      send_triangle(1, 1, 4095, 1'b0, idle);
      send_triangle(4095, 1, 4095, 1'b0, idle);
      send_triangle(2048, 2048, 1, 1'b0, idle);
      send_triangle(2730, 2730, 2730, 1'b0, idle);
      send_triangle(1365, 1365, 1365, 1'b0, idle);
      send_triangle(4, 5, 3, 1'b0, idle);
      send_triangle(10, 10, 10, 1'b1, idle);
      batches_sent++;
      wait_drained();

      rsp_calm <= 1'b1;
      idle = 1'b0;
      send_triangle(100, 100, 100, 1'b0, idle);
      send_triangle(50, 50, 50, 1'b0, idle);
      send_triangle(20, 20, 20, 1'b0, idle);
      send_triangle(7, 7, 7, 1'b0, idle);
      send_triangle(4095, 2048, 2048, 1'b0, idle);
      send_triangle(2, 2, 3, 1'b1, idle);
      batches_sent++;

      while (random_sent < RANDOM_ITEMS) begin
         if (batches_sent == 5) begin
            batch_size = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 4);
            items_dropped += batch_size - MAX_ITEMS;
         end else begin
            batch_size = $urandom_range(1, 12);
            if (batch_size > RANDOM_ITEMS - random_sent) batch_size = RANDOM_ITEMS - random_sent;
         end
         r = $urandom_range(0, 2);
         top_side = (r == 0) ? 15 : (r == 1) ? 255 : SIDE_MAX;
         idle = ($urandom_range(0, 3) != 0);
         rsp_calm <= ($urandom_range(0, 3) == 0);
         for (int i = 0; i < batch_size; i++) begin
            t = random_triangle(top_side, i > 0, prev);
            send_triangle(t.a, t.b, t.c, i == batch_size - 1, idle);
            prev = t;
         end
         random_sent += batch_size;
         batches_sent++;
         if ($urandom_range(0, 4) == 0) wait_drained();
      end

      wait_drained();
      repeat (16) @(posedge clock);
      $display("Sent %0d triangles in %0d batches, %0d of them beyond the store capacity.",
               items_sent, batches_sent, items_dropped);
      $display("Checked %0d sorted result beats under random gaps and output stalls.",
               checked_count);
      if (error_count == 0) begin
         $display("triangle_area_sorter regression: pass");
      end else begin
         $display("triangle_area_sorter regression: fail");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Timed out with %0d result beats still expected.", pending_count);
      $display("triangle_area_sorter regression: fail");
      $finish;
   end

endmodule

`default_nettype wire

### triangle_area_sorter.f
hw/rtl/tas_pkg.sv
hw/rtl/tas_key_unit.sv
hw/rtl/tas_cell.sv
hw/rtl/triangle_area_sorter.sv
hw/rtl/tas_checker.sv
tb/sv/triangle_area_sorter_checker.sv
tb/sv/triangle_area_sorter_test.sv
